// ===== rtl/pfi_pkg.sv =====
// Package: shared constants and types for the Pareto frontier insert block.
`timescale 1ns / 1ps

package pfi_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 20;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Command broadcast from the controller to every cell
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_CLEAR,
        CMD_MARK,
        CMD_SHIFT,
        CMD_PLACE
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMPACT,
        S_PLACE
    } t_state;

    // Contents of one cell
    typedef struct packed {
        logic                  valid;
        logic                  hole;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_entry;

    // Handed from each cell to its right neighbor
    typedef struct packed {
        logic lt;
        logic gt;
        logic seen;
    } t_link;

    // Per-cell status, also used for the chain-wide OR
    typedef struct packed {
        logic dom;
        logic eq;
        logic del;
        logic more;
    } t_flags;

endpackage

// ===== rtl/pfi_in_if.sv =====
// Interface: request channel carrying one point.
`timescale 1ns / 1ps

interface pfi_in_if import pfi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  clear_first;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;

    modport source (output valid, output clear_first, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input clear_first, input point_x, input point_y,
                    output ready);
endinterface

// ===== rtl/pfi_out_if.sv =====
// Interface: result channel carrying frontier status.
`timescale 1ns / 1ps

interface pfi_out_if import pfi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] frontier_size;
    logic             was_dominated;
    logic [CNT_W-1:0] removed_count;
    logic             table_overflow;

    modport source (output valid, output frontier_size, output was_dominated,
                    output removed_count, output table_overflow, input ready);
    modport sink   (input valid, input frontier_size, input was_dominated,
                    input removed_count, input table_overflow, output ready);
endinterface

// ===== rtl/pfi_cell.sv =====
// Cell: one slot of the sorted point chain with its local compare and move logic.
`timescale 1ns / 1ps

module pfi_cell import pfi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_place_new,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  t_link                 i_left_link,
    input  t_entry                i_left_entry,
    input  t_entry                i_right_entry,
    output t_link                 o_link,
    output t_entry                o_entry,
    output t_flags                o_flags
);

    logic                  r_valid, n_valid;
    logic                  r_hole, n_hole;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic                  w_lt, w_gt, w_eq, w_del;

    assign w_lt  = r_valid && (r_x < i_x);
    assign w_gt  = r_valid && (r_x > i_x);
    assign w_eq  = r_valid && (r_x == i_x);
    assign w_del = w_lt && (r_y < i_y);

    assign o_link  = '{lt: w_lt, gt: w_gt, seen: i_left_link.seen | r_hole};
    assign o_entry = '{valid: r_valid, hole: r_hole, x: r_x, y: r_y};
    // successor is the first cell above the new x
    assign o_flags = '{dom:  w_gt && !i_left_link.gt && (r_y > i_y),
                       eq:   w_eq,
                       del:  w_del,
                       more: r_hole && i_left_link.seen};

    always_comb begin
        n_valid = r_valid;
        n_hole  = r_hole;
        n_x     = r_x;
        n_y     = r_y;
        unique case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_CLEAR: begin
                n_valid = 1'b0;
                n_hole  = 1'b0;
            end
            CMD_MARK: begin
                n_hole = w_del;
            end
            CMD_SHIFT: begin
                // close the leftmost hole: everything from it rightward moves left
                if (i_left_link.seen || r_hole) begin
                    n_valid = i_right_entry.valid;
                    n_hole  = i_right_entry.hole;
                    n_x     = i_right_entry.x;
                    n_y     = i_right_entry.y;
                end
            end
            CMD_PLACE: begin
                n_hole = 1'b0;
                if (w_eq) begin
                    n_y = i_y;
                end else if (!w_lt && i_place_new) begin
                    if (i_left_link.lt) begin
                        n_valid = 1'b1;
                        n_x     = i_x;
                        n_y     = i_y;
                    end else begin
                        n_valid = i_left_entry.valid;
                        n_x     = i_left_entry.x;
                        n_y     = i_left_entry.y;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hole  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hole  <= n_hole;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

endmodule

// ===== rtl/pfi_chain.sv =====
// Chain: row of cells with neighbor wiring and chain-wide status OR.
`timescale 1ns / 1ps

module pfi_chain import pfi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_place_new,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    output t_flags                o_flags
);

    localparam t_entry EMPTY = '{valid: 1'b0, hole: 1'b0, x: '0, y: '0};

    t_link  w_link  [TABLE_DEPTH+1];
    t_entry w_entry [TABLE_DEPTH+2];
    t_flags w_flags [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] w_dom, w_eq, w_del, w_more;

    // left edge: cell 0 is the insert point if it is not below x
    assign w_link[0]                = '{lt: 1'b1, gt: 1'b0, seen: 1'b0};
    assign w_entry[0]               = EMPTY;
    assign w_entry[TABLE_DEPTH + 1] = EMPTY;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pfi_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (i_cmd),
            .i_place_new   (i_place_new),
            .i_x           (i_x),
            .i_y           (i_y),
            .i_left_link   (w_link[g]),
            .i_left_entry  (w_entry[g]),
            .i_right_entry (w_entry[g + 2]),
            .o_link        (w_link[g + 1]),
            .o_entry       (w_entry[g + 1]),
            .o_flags       (w_flags[g])
        );
        assign w_dom[g]  = w_flags[g].dom;
        assign w_eq[g]   = w_flags[g].eq;
        assign w_del[g]  = w_flags[g].del;
        assign w_more[g] = w_flags[g].more;
    end

    assign o_flags = '{dom: |w_dom, eq: |w_eq, del: |w_del, more: |w_more};

endmodule

// ===== rtl/pareto_frontier_insert_core.sv =====
// Top level: incremental 2-D Pareto frontier kept in a sorted chain of cells.
`timescale 1ns / 1ps
//
//  Channel | Dir | Modport         | Payload
//  --------+-----+-----------------+---------------------------------------------
//  i_in    | in  | pfi_in_if.sink  | clear_first, point_x, point_y
//  o_out   | out | pfi_out_if.source | frontier_size, was_dominated,
//          |     |                 | removed_count, table_overflow
//
//  Steps: accept, then one compare/insert step across all cells when no stored
//  point is removed; when points are removed, accept, evaluate and mark, then
//  one chain shift per removed point plus the insert step.
//  Reset: clears the point count and every cell's valid bit at once; no sweep.
//  Stalls: the result sits in an output register, so the next request is
//  accepted while it waits; only a finishing step waits if that register is
//  still full and not being taken.
//
//  Flow: IDLE takes the request (clearing the chain if asked). EVAL compares
//  the point against every cell in parallel: the first cell above x decides
//  dominance, cells below in both x and y are marked as holes. COMPACT closes
//  the leftmost hole per cycle. PLACE updates an equal x or opens a slot at
//  the first cell not below x, if there is room, by shifting the right part one step.

module pareto_frontier_insert_core import pfi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pfi_in_if.sink           i_in,
    pfi_out_if.source        o_out
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_removed, n_removed;
    logic                  r_equal, n_equal;
    logic [COORD_BITS-1:0] r_x, r_y;

    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_out_size;
    logic                  r_out_dom;
    logic [CNT_W-1:0]      r_out_removed;
    logic                  r_out_ovf;

    t_cmd   w_cmd;
    t_flags w_flags;
    logic   w_accept, w_out_free, w_finish, w_equal_now, w_room, w_place_new;
    logic   w_res_dom, w_res_ovf;

    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_equal_now = (r_state == S_EVAL) ? w_flags.eq : r_equal;
    assign w_room      = r_count < CNT_W'(TABLE_DEPTH);
    assign w_place_new = !w_equal_now && w_room;

    pfi_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_place_new (w_place_new),
        .i_x         (r_x),
        .i_y         (r_y),
        .o_flags     (w_flags)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_removed = r_removed;
        n_equal   = r_equal;
        w_cmd     = CMD_HOLD;
        w_finish  = 1'b0;
        w_res_dom = 1'b0;
        w_res_ovf = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = S_EVAL;
                    n_removed = '0;
                    if (i_in.clear_first) begin
                        w_cmd   = CMD_CLEAR;
                        n_count = '0;
                    end
                end
            end
            S_EVAL: begin
                n_equal = w_flags.eq;
                if (w_flags.dom) begin
                    if (w_out_free) begin
                        w_finish  = 1'b1;
                        w_res_dom = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (w_flags.del) begin
                    w_cmd   = CMD_MARK;
                    n_state = S_COMPACT;
                end else if (w_out_free) begin
                    w_cmd     = CMD_PLACE;
                    w_finish  = 1'b1;
                    w_res_ovf = !w_equal_now && !w_room;
                    n_count   = r_count + CNT_W'(w_place_new);
                    n_state   = S_IDLE;
                end
            end
            S_COMPACT: begin
                w_cmd     = CMD_SHIFT;
                n_count   = r_count - CNT_W'(1);
                n_removed = r_removed + CNT_W'(1);
                if (!w_flags.more) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (w_out_free) begin
                    // removal left a free slot, so no overflow here
                    w_cmd     = CMD_PLACE;
                    w_finish  = 1'b1;
                    w_res_ovf = !w_equal_now && !w_room;
                    n_count   = r_count + CNT_W'(w_place_new);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed <= n_removed;
        r_equal   <= n_equal;
        if (w_accept) begin
            r_x <= i_in.point_x;
            r_y <= i_in.point_y;
        end
        if (w_finish) begin
            r_out_size    <= n_count;
            r_out_dom     <= w_res_dom;
            r_out_removed <= n_removed;
            r_out_ovf     <= w_res_ovf;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.frontier_size  = r_out_size;
    assign o_out.was_dominated  = r_out_dom;
    assign o_out.removed_count  = r_out_removed;
    assign o_out.table_overflow = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("point count above table depth");

    a_compact_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPACT) |-> (r_count != '0))
        else $error("compaction with an empty table");

    a_dom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dom) |-> (r_out_removed == '0 && !r_out_ovf))
        else $error("dropped point reports removals or overflow");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_EVAL))
        else $error("accepted request did not enter evaluation");

    a_ovf_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && w_res_ovf) |-> (n_removed == '0 && r_count == CNT_W'(TABLE_DEPTH)))
        else $error("overflow reported with room in the table");

endmodule
